@@ sv/izh_pkg.sv @@
// shared types, register codes, reset values and saturating arithmetic
// for the izhikevich neuron step core; no dependencies
package izh_pkg;

  localparam int DataW = 32;
  localparam int ProdW = 64;
  localparam int RegIdxW = 3;

  // register indexes on the configuration port
  localparam logic [RegIdxW-1:0] REG_RECOVERY_RATE     = 3'd0;
  localparam logic [RegIdxW-1:0] REG_RECOVERY_GAIN     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_RESET_VOLTAGE     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_RECOVERY_JUMP     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_QUADRATIC_GAIN    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_REST_VOLTAGE      = 3'd5;
  localparam logic [RegIdxW-1:0] REG_THRESHOLD_VOLTAGE = 3'd6;
  localparam logic [RegIdxW-1:0] REG_PEAK_VOLTAGE      = 3'd7;

  // reset values, q16.16
  localparam logic signed [DataW-1:0] RST_RECOVERY_RATE     = 32'sd655;
  localparam logic signed [DataW-1:0] RST_RECOVERY_GAIN     = 32'sd3277;
  localparam logic signed [DataW-1:0] RST_RESET_VOLTAGE     = -32'sd3932160;
  localparam logic signed [DataW-1:0] RST_RECOVERY_JUMP     = 32'sd262144;
  localparam logic signed [DataW-1:0] RST_QUADRATIC_GAIN    = 32'sd1966;
  localparam logic signed [DataW-1:0] RST_REST_VOLTAGE      = -32'sd3932160;
  localparam logic signed [DataW-1:0] RST_THRESHOLD_VOLTAGE = -32'sd3276800;
  localparam logic signed [DataW-1:0] RST_PEAK_VOLTAGE      = 32'sd3276800;

  // input kind on tuser
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_INIT    = 1'b1;

  // multiplier operand pairs
  localparam logic [1:0] MSEL_K_D1 = 2'd0;
  localparam logic [1:0] MSEL_Q_D2 = 2'd1;
  localparam logic [1:0] MSEL_B_E  = 2'd2;
  localparam logic [1:0] MSEL_A_H  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] mul_sel;
    logic       rnd;
    logic       vn;
    logic       fin;
  } izh_cmd_t;

  localparam logic signed [DataW-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SAT_MIN = 32'sh80000000;

  function automatic logic signed [DataW-1:0] sadd(input logic signed [DataW-1:0] x,
                                                   input logic signed [DataW-1:0] y);
    logic signed [DataW:0] s;
    s = {x[DataW-1], x} + {y[DataW-1], y};
    if (s[DataW] != s[DataW-1]) return s[DataW] ? SAT_MIN : SAT_MAX;
    return s[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] ssub(input logic signed [DataW-1:0] x,
                                                   input logic signed [DataW-1:0] y);
    logic signed [DataW:0] s;
    s = {x[DataW-1], x} - {y[DataW-1], y};
    if (s[DataW] != s[DataW-1]) return s[DataW] ? SAT_MIN : SAT_MAX;
    return s[DataW-1:0];
  endfunction

  // round half up to q16.16 and saturate
  function automatic logic signed [DataW-1:0] qround(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    logic [ProdW-1:47] top;
    s = p + 64'sd32768;
    top = s[ProdW-1:47];
    if (top != '0 && top != '1) return s[ProdW-1] ? SAT_MIN : SAT_MAX;
    return s[47:16];
  endfunction

endpackage

@@ sv/izh_ctrl.sv @@
// sequencer for the neuron step: input and output handshakes and
// datapath commands; depends on izh_pkg
module izh_ctrl import izh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     s_act,
  output logic     m_tvalid,
  input  logic     m_tready,
  output izh_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_R1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_R2   = 4'd4;
  localparam logic [3:0] ST_VN   = 4'd5;
  localparam logic [3:0] ST_M3   = 4'd6;
  localparam logic [3:0] ST_R3   = 4'd7;
  localparam logic [3:0] ST_M4   = 4'd8;
  localparam logic [3:0] ST_R4   = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0] state, state_next;
  logic       out_valid, out_valid_next;
  logic       slot_free;

  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;
  assign slot_free = !out_valid || m_tready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MSEL_K_D1;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = (s_act == ACT_INIT) ? ST_DONE : ST_M1;
        end
      end
      ST_M1: begin
        cmd.mul = 1'b1; cmd.mul_sel = MSEL_K_D1; state_next = ST_R1;
      end
      ST_R1: begin
        cmd.rnd = 1'b1; state_next = ST_M2;
      end
      ST_M2: begin
        cmd.mul = 1'b1; cmd.mul_sel = MSEL_Q_D2; state_next = ST_R2;
      end
      ST_R2: begin
        cmd.rnd = 1'b1; state_next = ST_VN;
      end
      ST_VN: begin
        cmd.vn = 1'b1; state_next = ST_M3;
      end
      ST_M3: begin
        cmd.mul = 1'b1; cmd.mul_sel = MSEL_B_E; state_next = ST_R3;
      end
      ST_R3: begin
        cmd.rnd = 1'b1; state_next = ST_M4;
      end
      ST_M4: begin
        cmd.mul = 1'b1; cmd.mul_sel = MSEL_A_H; state_next = ST_R4;
      end
      ST_R4: begin
        cmd.rnd = 1'b1; state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.fin) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ sv/izh_dp.sv @@
// datapath: configuration registers, neuron state, one shared 32x32
// multiplier with rounding stage, result register; depends on izh_pkg
module izh_dp import izh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [RegIdxW-1:0]        cfg_index,
  input  logic [DataW-1:0]          cfg_data,
  input  izh_cmd_t                  cmd,
  input  logic                      in_act,
  input  logic signed [DataW-1:0]   in_cur,
  output logic                      out_spike,
  output logic signed [DataW-1:0]   out_v,
  output logic signed [DataW-1:0]   out_u
);

  logic signed [DataW-1:0] r_a, r_b, r_c, r_d, r_k, r_vr, r_vth, r_vp;
  logic signed [DataW-1:0] volt, recov;
  logic                    act;
  logic signed [DataW-1:0] cur, d1, d2, qr, vn;
  logic signed [ProdW-1:0] prod;
  logic signed [DataW-1:0] op_a, op_b;
  logic signed [DataW-1:0] un, un_jump;
  logic                    fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_a   <= RST_RECOVERY_RATE;
      r_b   <= RST_RECOVERY_GAIN;
      r_c   <= RST_RESET_VOLTAGE;
      r_d   <= RST_RECOVERY_JUMP;
      r_k   <= RST_QUADRATIC_GAIN;
      r_vr  <= RST_REST_VOLTAGE;
      r_vth <= RST_THRESHOLD_VOLTAGE;
      r_vp  <= RST_PEAK_VOLTAGE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECOVERY_RATE:     r_a   <= cfg_data;
        REG_RECOVERY_GAIN:     r_b   <= cfg_data;
        REG_RESET_VOLTAGE:     r_c   <= cfg_data;
        REG_RECOVERY_JUMP:     r_d   <= cfg_data;
        REG_QUADRATIC_GAIN:    r_k   <= cfg_data;
        REG_REST_VOLTAGE:      r_vr  <= cfg_data;
        REG_THRESHOLD_VOLTAGE: r_vth <= cfg_data;
        REG_PEAK_VOLTAGE:      r_vp  <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MSEL_K_D1: begin op_a = r_k; op_b = d1; end
      MSEL_Q_D2: begin op_a = qr;  op_b = d2; end
      MSEL_B_E:  begin op_a = r_b; op_b = ssub(vn, r_vr); end
      MSEL_A_H:  begin op_a = r_a; op_b = ssub(qr, recov); end
      default:   begin op_a = r_k; op_b = d1; end
    endcase
  end

  assign un      = sadd(recov, qr);
  assign un_jump = sadd(un, r_d);
  assign fire    = (vn > r_vp);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_act;
      cur <= in_cur;
      d1  <= ssub(volt, r_vr);
      d2  <= ssub(volt, r_vth);
    end
    if (cmd.mul) prod <= op_a * op_b;
    if (cmd.rnd) qr <= qround(prod);
    if (cmd.vn) vn <= sadd(volt, sadd(ssub(qr, recov), cur));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt  <= RST_REST_VOLTAGE;
      recov <= '0;
    end else if (cmd.fin) begin
      if (act == ACT_INIT) begin
        volt  <= r_vr;
        recov <= '0;
      end else if (fire) begin
        volt  <= r_c;
        recov <= un_jump;
      end else begin
        volt  <= vn;
        recov <= un;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (act == ACT_INIT) begin
        out_spike <= 1'b0;
        out_v     <= r_vr;
        out_u     <= '0;
      end else begin
        out_spike <= fire;
        out_v     <= fire ? r_c : vn;
        out_u     <= fire ? un_jump : un;
      end
    end
  end

endmodule

@@ sv/izhikevich_neuron_step_core.sv @@
// izhikevich neuron step core: one euler step of v and u per advance input;
// an initialize input sets v to rest voltage and u = 0 without any products;
// for advance the sequencer runs four dependent products through one shared 32x32
// multiplier, each followed by a rounding step, so one item is in work at a time
// and a new input is taken only once the last result is in the output register
// rst (synchronous) restores register defaults, v = rest voltage, u = 0
module izhikevich_neuron_step_core import izh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [RegIdxW-1:0]  cfg_index,
  input  logic [DataW-1:0]    cfg_data,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,   // [31:0] drive_current
  input  logic                s_tuser,   // [0] action
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,   // [31:0] membrane_voltage, [63:32] recovery_level
  output logic                m_tuser    // [0] spike
);

  izh_cmd_t                cmd;
  logic signed [DataW-1:0] out_v, out_u;

  // controller: handshakes and step sequence
  izh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_act    (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // datapath: state, shared multiplier, result register
  izh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_act    (s_tuser),
    .in_cur    ($signed(s_tdata)),
    .out_spike (m_tuser),
    .out_v     (out_v),
    .out_u     (out_u)
  );

  // pack result fields, first field lowest
  assign m_tdata = {out_u, out_v};

endmodule
